/* hw/rtl/fvs_pkg.sv */
// Shared constants and types for the focus list vertex scheduler.
`timescale 1ns / 1ps

package fvs_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_LIST_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd1;

  localparam int LIMIT_W = 11;
  localparam int COUNT_W = 21;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 11'd256;
  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 21'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 21'h1FFFFF;

  // Credit handed to a freshly appended entry, and credit gained per lift
  localparam int START_CREDIT = 2;
  localparam int CREDIT_STEP  = 2;

  // Status from the controller to the top level
  typedef struct packed {
    logic busy;      // an item is in work, no new item taken
    logic pass_two;  // cycling through the focus list
  } fvs_status_t;

endpackage

/* hw/rtl/fvs_list_mem.sv */
// Focus list storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module fvs_list_mem #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 36,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/fvs_ctrl.sv */
// Scheduler sequencer: pass one append, pass two read-modify-write and order-keeping removal.
`timescale 1ns / 1ps

module fvs_ctrl
  import fvs_pkg::*;
#(
  parameter int MAX_LIST    = 1024,
  parameter int VERTEX_BITS = 20,
  parameter int CREDIT_BITS = 16,
  parameter int ADDR_W      = 10,
  parameter int WORD_W      = 36
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [VERTEX_BITS-1:0] in_vertex,
  input  logic                   in_none,
  input  logic                   in_lifted,
  input  logic [LIMIT_W-1:0]     list_limit,
  input  logic [COUNT_W-1:0]     vertex_count,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [VERTEX_BITS-1:0] out_vertex,
  output logic                   out_delegate,
  output logic                   out_focus,
  output fvs_status_t            status,
  output logic                   mem_we,
  output logic [ADDR_W-1:0]      mem_waddr,
  output logic [WORD_W-1:0]      mem_wdata,
  output logic                   mem_re,
  output logic [ADDR_W-1:0]      mem_raddr,
  input  logic [WORD_W-1:0]      mem_rdata
);

  localparam int LEN_W = $clog2(MAX_LIST + 1);
  localparam int CMP_W = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P1,
    ST_MOD,
    ST_SHIFT,
    ST_RD,
    ST_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [LEN_W-1:0]       rp_r, rp_nxt;
  logic [ADDR_W-1:0]      sh_r, sh_nxt;
  logic                   pass_two_r, pass_two_nxt;
  logic [COUNT_W-1:0]     att_r, att_nxt;
  logic                   sv_valid_r, sv_valid_nxt;
  logic                   sv_lifted_r, sv_lifted_nxt;
  logic [VERTEX_BITS-1:0] sv_vtx_r, sv_vtx_nxt;
  logic                   rep_none_r, rep_none_nxt;
  logic                   rep_lifted_r, rep_lifted_nxt;
  logic [VERTEX_BITS-1:0] rep_vtx_r, rep_vtx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VERTEX_BITS-1:0] out_vtx_r, out_vtx_nxt;
  logic                   out_del_r, out_del_nxt;
  logic                   out_focus_r, out_focus_nxt;

  logic                   out_free;
  logic                   in_take;

  // pass one
  logic                   p1_app;
  logic [LEN_W-1:0]       p1_len;
  logic [CMP_W-1:0]       lim_c;
  logic                   p1_sw;
  logic                   p1_go2;
  logic [COUNT_W-1:0]     p1_att0;
  logic [COUNT_W-1:0]     p1_att;

  // pass two
  logic [CREDIT_BITS-1:0] rd_crd;
  logic [VERTEX_BITS-1:0] rd_vtx;
  logic [CREDIT_BITS:0]   crd_sum;
  logic [CREDIT_BITS-1:0] crd_up;
  logic [CREDIT_BITS-1:0] crd_half;
  logic                   mod_drop;
  logic [LEN_W-1:0]       rp_inc;
  logic [LEN_W-1:0]       sh_two;

  assign out_free = !out_valid_r || out_ready;
  assign in_take  = in_valid && (state_r == ST_IDLE);

  assign p1_app = rep_lifted_r && !rep_none_r && (len_r < LEN_W'(MAX_LIST));
  assign p1_len = len_r + LEN_W'(p1_app);

  always_comb begin
    if (list_limit == '0) begin
      lim_c = CMP_W'(1);
    end else if (CMP_W'(list_limit) > CMP_W'(MAX_LIST)) begin
      lim_c = CMP_W'(MAX_LIST);
    end else begin
      lim_c = CMP_W'(list_limit);
    end
  end

  assign p1_sw   = (CMP_W'(p1_len) >= lim_c) || (att_r >= vertex_count);
  assign p1_go2  = p1_sw && (p1_len != '0);
  assign p1_att0 = p1_sw ? '0 : att_r;
  assign p1_att  = (p1_att0 != COUNT_MAX) ? p1_att0 + COUNT_W'(1) : p1_att0;

  assign rd_crd   = mem_rdata[CREDIT_BITS-1:0];
  assign rd_vtx   = mem_rdata[CREDIT_BITS +: VERTEX_BITS];
  assign crd_sum  = {1'b0, rd_crd} + (CREDIT_BITS+1)'(CREDIT_STEP);
  assign crd_up   = crd_sum[CREDIT_BITS] ? '1 : crd_sum[CREDIT_BITS-1:0];
  assign crd_half = rd_crd >> 1;
  assign mod_drop = !rep_lifted_r && (crd_half == '0);
  assign rp_inc   = rp_r + LEN_W'(1);
  assign sh_two   = LEN_W'(sh_r) + LEN_W'(2);

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    rp_nxt         = rp_r;
    sh_nxt         = sh_r;
    pass_two_nxt   = pass_two_r;
    att_nxt        = att_r;
    sv_valid_nxt   = sv_valid_r;
    sv_lifted_nxt  = sv_lifted_r;
    sv_vtx_nxt     = sv_vtx_r;
    rep_none_nxt   = rep_none_r;
    rep_lifted_nxt = rep_lifted_r;
    rep_vtx_nxt    = rep_vtx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_vtx_nxt    = out_vtx_r;
    out_del_nxt    = out_del_r;
    out_focus_nxt  = out_focus_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          rep_none_nxt   = in_none;
          rep_lifted_nxt = in_lifted;
          rep_vtx_nxt    = in_vertex;
          if (pass_two_r) begin
            mem_re = 1'b1;
            if (in_none) begin
              // restart the cycle at the list head
              rp_nxt    = '0;
              mem_raddr = '0;
              state_nxt = ST_EMIT;
            end else begin
              mem_raddr = rp_r[ADDR_W-1:0];
              state_nxt = ST_MOD;
            end
          end else begin
            state_nxt = ST_P1;
          end
        end
      end

      ST_P1: begin
        if (out_free) begin
          sv_valid_nxt  = !rep_none_r;
          sv_lifted_nxt = rep_lifted_r;
          sv_vtx_nxt    = rep_vtx_r;
          if (p1_app) begin
            mem_we    = 1'b1;
            mem_waddr = len_r[ADDR_W-1:0];
            mem_wdata = {rep_vtx_r, CREDIT_BITS'(START_CREDIT)};
          end
          len_nxt = p1_len;
          if (p1_go2) begin
            pass_two_nxt = 1'b1;
            rp_nxt       = '0;
            state_nxt    = ST_RD;
          end else begin
            att_nxt       = p1_att;
            out_valid_nxt = 1'b1;
            out_vtx_nxt   = '0;
            out_del_nxt   = 1'b1;
            out_focus_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end

      ST_MOD: begin
        if (!mod_drop) begin
          mem_we    = 1'b1;
          mem_waddr = rp_r[ADDR_W-1:0];
          mem_wdata = {rd_vtx, rep_lifted_r ? crd_up : crd_half};
          mem_re    = 1'b1;
          // a write-back only touches credit, so a same-address read still
          // returns the right vertex
          if (rp_inc >= len_r) begin
            rp_nxt    = '0;
            mem_raddr = '0;
          end else begin
            rp_nxt    = rp_inc;
            mem_raddr = rp_inc[ADDR_W-1:0];
          end
          state_nxt = ST_EMIT;
        end else if (rp_inc < len_r) begin
          // close the gap: move later entries down one slot
          mem_re    = 1'b1;
          mem_raddr = rp_inc[ADDR_W-1:0];
          sh_nxt    = rp_r[ADDR_W-1:0];
          state_nxt = ST_SHIFT;
        end else begin
          // tail entry dropped, nothing to move
          len_nxt = len_r - LEN_W'(1);
          rp_nxt  = '0;
          if (len_r == LEN_W'(1)) begin
            // list empty: back to pass one, replay the saved report
            pass_two_nxt   = 1'b0;
            att_nxt        = '0;
            rep_none_nxt   = !sv_valid_r;
            rep_lifted_nxt = sv_lifted_r;
            rep_vtx_nxt    = sv_vtx_r;
            state_nxt      = ST_P1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = sh_r;
        mem_wdata = mem_rdata;
        if (sh_two < len_r) begin
          mem_re    = 1'b1;
          mem_raddr = sh_two[ADDR_W-1:0];
          sh_nxt    = sh_r + ADDR_W'(1);
        end else begin
          len_nxt   = len_r - LEN_W'(1);
          state_nxt = ST_RD;
        end
      end

      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = rp_r[ADDR_W-1:0];
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vtx_nxt   = rd_vtx;
          out_del_nxt   = 1'b0;
          out_focus_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      rp_r        <= '0;
      pass_two_r  <= 1'b0;
      att_r       <= '0;
      sv_valid_r  <= 1'b0;
      sv_lifted_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rp_r        <= rp_nxt;
      pass_two_r  <= pass_two_nxt;
      att_r       <= att_nxt;
      sv_valid_r  <= sv_valid_nxt;
      sv_lifted_r <= sv_lifted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sh_r         <= sh_nxt;
    sv_vtx_r     <= sv_vtx_nxt;
    rep_none_r   <= rep_none_nxt;
    rep_lifted_r <= rep_lifted_nxt;
    rep_vtx_r    <= rep_vtx_nxt;
    out_vtx_r    <= out_vtx_nxt;
    out_del_r    <= out_del_nxt;
    out_focus_r  <= out_focus_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_vertex      = out_vtx_r;
  assign out_delegate    = out_del_r;
  assign out_focus       = out_focus_r;
  assign status.busy     = (state_r != ST_IDLE);
  assign status.pass_two = pass_two_r;

endmodule

/* hw/rtl/focus_list_vertex_scheduler_top.sv */
// Top level of the focus list vertex scheduler: ports, configuration registers, list memory.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata: reported vertex; tuser: none, lifted
//  out_    | out | out_tvalid / out_tready| tdata: chosen_vertex; tuser: delegate, pass
//  cfg_    | in  | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One item at a time. A pass one report goes through P1; entering pass two adds a list head
// read (RD, then EMIT). A pass two report reads its entry in IDLE, writes back the credit in
// MOD and hands out the next entry in EMIT, as the single list memory has registered read data;
// a report with no previous vertex reads the head only. Removing an entry ahead of the tail
// adds the order-keeping shift (one entry moved per cycle); dropping the tail entry needs no
// shift, and an emptied list replays pass one.
// Reset is synchronous; the list memory is not cleared, only entries below the length are read.
// A result waits in the output register while out_tready is low; the next item is accepted
// meanwhile and its result is held back until the register frees.
`timescale 1ns / 1ps

module focus_list_vertex_scheduler_top
  import fvs_pkg::*;
#(
  parameter int MAX_LIST    = 1024,
  parameter int VERTEX_BITS = 20,
  parameter int CREDIT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [((VERTEX_BITS+7)/8)*8-1:0] in_tdata,  // [VERTEX_BITS-1:0] reported vertex
  input  logic [1:0]             in_tuser,   // [0] no previous vertex, [1] lift flag
  // result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [((VERTEX_BITS+7)/8)*8-1:0] out_tdata, // [VERTEX_BITS-1:0] chosen_vertex, rest 0
  output logic [1:0]             out_tuser,  // [0] delegate, [1] in_focus_pass
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DATA_W = ((VERTEX_BITS + 7) / 8) * 8;
  localparam int ADDR_W = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int WORD_W = VERTEX_BITS + CREDIT_BITS;

  logic [LIMIT_W-1:0]     list_limit_r, list_limit_nxt;
  logic [COUNT_W-1:0]     vcount_r, vcount_nxt;

  fvs_status_t            status;
  logic [VERTEX_BITS-1:0] out_vertex;
  logic                   out_delegate;
  logic                   out_focus;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [WORD_W-1:0]      mem_wdata;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [WORD_W-1:0]      mem_rdata;

  // configuration registers: the user writes them only while idle; the block does not enforce it
  always_comb begin
    list_limit_nxt = list_limit_r;
    vcount_nxt     = vcount_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LIST_LIMIT:   list_limit_nxt = cfg_wdata[LIMIT_W-1:0];
        CFG_VERTEX_COUNT: vcount_nxt     = cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_limit_r <= LIMIT_RESET;
      vcount_r     <= VCOUNT_RESET;
    end else begin
      list_limit_r <= list_limit_nxt;
      vcount_r     <= vcount_nxt;
    end
  end

  fvs_ctrl #(
    .MAX_LIST    (MAX_LIST),
    .VERTEX_BITS (VERTEX_BITS),
    .CREDIT_BITS (CREDIT_BITS),
    .ADDR_W      (ADDR_W),
    .WORD_W      (WORD_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_vertex    (in_tdata[VERTEX_BITS-1:0]),
    .in_none      (in_tuser[0]),
    .in_lifted    (in_tuser[1]),
    .list_limit   (list_limit_r),
    .vertex_count (vcount_r),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_vertex   (out_vertex),
    .out_delegate (out_delegate),
    .out_focus    (out_focus),
    .status       (status),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // each word: {vertex, credit}
  fvs_list_mem #(
    .DEPTH  (MAX_LIST),
    .WIDTH  (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_list_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_tready = !status.busy;
  assign out_tdata = DATA_W'(out_vertex);
  assign out_tuser = {out_focus, out_delegate};

`ifndef SYNTHESIS
  // an accepted item makes the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous one still in work");

  // the pass changes only while an item is in work
  a_pass_change_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.pass_two) || $fell(status.pass_two) |-> $past(!in_tready) ||
      $past(in_tvalid))
    else $error("pass changed with no item in work");

  // a freshly shown result carries the pass the block is in
  a_result_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> out_tuser[1] == status.pass_two)
    else $error("result pass flag disagrees with block pass");

  // a list vertex is only handed out in pass two
  a_delegate_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && !out_tuser[0] |-> status.pass_two && out_tuser[1])
    else $error("list vertex handed out outside pass two");
`endif

endmodule

/* tb/tb_focus_list_vertex_scheduler_top.sv */
// Self-checking testbench for the focus list vertex scheduler top level.
`timescale 1ns / 1ps

module tb_focus_list_vertex_scheduler_top
  import fvs_pkg::*;
();

  localparam int VBITS       = 20;
  localparam int CBITS       = 16;
  localparam int LIST_DEPTH  = 1024;
  localparam int DATA_W      = ((VBITS + 7) / 8) * 8;
  localparam int STALL_LIMIT = 20000;   // cycles with no item moving on either side
  localparam int SOAK_LIFTS  = 24;      // lifts on one entry, credit climbs well past its start
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 135;

  localparam logic [CBITS-1:0] CREDIT_TOP = '1;

  // One scheduling decision as it leaves the block
  typedef struct packed {
    logic [VBITS-1:0] vertex;
    logic             delegate;
    logic             focus;
  } choice_t;

  localparam choice_t DELEGATED = '{vertex: '0, delegate: 1'b1, focus: 1'b0};

  typedef enum logic {ROW_REPORT, ROW_WRITE} row_kind_t;

  // Directed script row: either a report to send or a register to write.
  // Where typed is set, want is the result read straight off the behaviour.
  typedef struct packed {
    row_kind_t             kind;
    logic [VBITS-1:0]      vertex;
    logic                  none;
    logic                  lifted;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  typed;
    choice_t               want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata;   // [19:0] reported vertex, rest 0
  logic [1:0]            in_tuser;   // [0] no previous vertex, [1] lift flag
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;  // [19:0] chosen_vertex, rest 0
  logic [1:0]            out_tuser;  // [0] delegate, [1] in_focus_pass
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  focus_list_vertex_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler mirror: the focus list, pass flag, attempt counter, the last
  // pass-one report (replayed once the list runs dry) and both registers.
  // ---------------------------------------------------------------------------
  logic [VBITS-1:0]   fl_vertex [LIST_DEPTH];
  logic [CBITS-1:0]   fl_credit [LIST_DEPTH];
  int                 fl_len = 0;
  int                 fl_rd  = 0;
  bit                 in_pass_two = 1'b0;
  logic [COUNT_W-1:0] tries = '0;
  logic [VBITS-1:0]   last_vertex = '0;
  bit                 last_valid  = 1'b0;
  bit                 last_lifted = 1'b0;
  logic [LIMIT_W-1:0] limit_reg  = LIMIT_RESET;
  logic [COUNT_W-1:0] vcount_reg = VCOUNT_RESET;

  choice_t            pending_choices [$];   // results still owed by the block
  logic [VBITS-1:0]   handed_vertex = '0;    // last vertex the block handed out
  int                 idle_pct = 33;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;

  // Entry at the read pointer; an out-of-range pointer falls back to the head
  function automatic choice_t head_choice();
    choice_t c;
    c.vertex   = fl_vertex[(fl_rd < fl_len) ? fl_rd : 0];
    c.delegate = 1'b0;
    c.focus    = 1'b1;
    return c;
  endfunction

  // Pass one: collect lifted vertices, hand work to the linear scanner
  function automatic choice_t scan_pass_choice(input bit none, input logic [VBITS-1:0] v,
                                               input bit lifted);
    int lim;
    last_valid  = !none;
    last_vertex = v;
    last_lifted = lifted;
    if (lifted && !none && fl_len < LIST_DEPTH) begin
      fl_vertex[fl_len] = v;
      fl_credit[fl_len] = CBITS'(START_CREDIT);
      fl_len++;
    end
    lim = limit_reg;
    if (lim < 1) lim = 1;
    if (lim > LIST_DEPTH) lim = LIST_DEPTH;
    if (fl_len >= lim || tries >= vcount_reg) begin
      if (fl_len > 0) begin
        in_pass_two = 1'b1;
        fl_rd = 0;
        return head_choice();
      end
      // nothing collected: stay in pass one and start counting again
      tries = '0;
    end
    if (tries != COUNT_MAX) tries++;
    return DELEGATED;
  endfunction

  // Pass two: the report applies to the entry at the read pointer
  function automatic choice_t focus_pass_choice(input bit none, input bit lifted);
    int           p;
    int           i;
    logic [CBITS:0] sum;
    if (none) begin
      fl_rd = 0;
    end else if (fl_rd < fl_len) begin
      p = fl_rd;
      if (lifted) begin
        sum = {1'b0, fl_credit[p]} + (CBITS+1)'(CREDIT_STEP);
        fl_credit[p] = (sum > CREDIT_TOP) ? CREDIT_TOP : sum[CBITS-1:0];
        fl_rd = p + 1;
      end else begin
        fl_credit[p] = fl_credit[p] >> 1;
        if (fl_credit[p] == '0) begin
          for (i = p; i < fl_len - 1; i++) begin
            fl_vertex[i] = fl_vertex[i+1];
            fl_credit[i] = fl_credit[i+1];
          end
          fl_len--;
        end else begin
          fl_rd = p + 1;
        end
      end
    end
    if (fl_rd >= fl_len) begin
      if (fl_len == 0) begin
        in_pass_two = 1'b0;
        tries = '0;
        fl_rd = 0;
        return scan_pass_choice(!last_valid, last_vertex, last_lifted);
      end
      fl_rd = 0;
    end
    return head_choice();
  endfunction

  function automatic choice_t predict_choice(input logic [VBITS-1:0] v, input bit none,
                                             input bit lifted);
    if (in_pass_two) return focus_pass_choice(none, lifted);
    return scan_pass_choice(none, v, lifted);
  endfunction

  // ---------------------------------------------------------------------------
  // Script row builders
  // ---------------------------------------------------------------------------
  function automatic script_row_t report_row(input logic [VBITS-1:0] v, input bit none,
                                             input bit lifted);
    script_row_t r;
    r        = '0;
    r.kind   = ROW_REPORT;
    r.vertex = v;
    r.none   = none;
    r.lifted = lifted;
    return r;
  endfunction

  function automatic script_row_t known_row(input logic [VBITS-1:0] v, input bit none,
                                            input bit lifted, input choice_t want);
    script_row_t r;
    r       = report_row(v, none, lifted);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
    script_row_t r;
    r         = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Every input changes by NBA at a rising edge; acceptance is read
  // at the edge itself, so the values seen are those from before the edge.
  // ---------------------------------------------------------------------------

  // Offer one report, idling at random first. Valid stays high on return so
  // a following report goes out back to back.
  task automatic offer_report(input logic [VBITS-1:0] v, input bit none, input bit lifted,
                              input bit typed, input choice_t want);
    choice_t c;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'(v);
    in_tuser  <= {lifted, none};
    do @(posedge clk); while (!in_tready);
    c = predict_choice(v, none, lifted);
    if (!c.delegate) handed_vertex = c.vertex;
    pending_choices.insert(pending_choices.size(), typed ? want : c);
  endtask

  // Hold the sender until every owed result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_choices.size() != 0);
  endtask

  // Single register write; the enable is dropped by the next report
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_LIST_LIMIT) limit_reg = val[LIMIT_W-1:0];
    else if (idx == CFG_VERTEX_COUNT) vcount_reg = val[COUNT_W-1:0];
  endtask

  // Result sink: random back-pressure at the rate idle_pct sets
  always @(posedge clk) out_tready <= ($urandom_range(99) >= idle_pct);

  // ---------------------------------------------------------------------------
  // Result checker and stall counter
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    choice_t want;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_choices.size() == 0) begin
        $error("unexpected result: chosen_vertex %h delegate %b in_focus_pass %b",
               out_tdata[VBITS-1:0], out_tuser[0], out_tuser[1]);
        mismatches++;
      end else begin
        want = pending_choices.pop_front();
        if (out_tdata[VBITS-1:0] !== want.vertex) begin
          $error("chosen_vertex: expected %h, got %h", want.vertex, out_tdata[VBITS-1:0]);
          mismatches++;
        end
        if (out_tuser[0] !== want.delegate) begin
          $error("delegate: expected %b, got %b", want.delegate, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== want.focus) begin
          $error("in_focus_pass: expected %b, got %b", want.focus, out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: nothing moving for too long means the block has hung
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t      script [$];
    logic [VBITS-1:0] v;
    bit               none;
    bit               lifted;
    int               lift_pct;
    int               phase;
    int               k;
    logic [CFG_DATA_W-1:0] lim_val;
    logic [CFG_DATA_W-1:0] cnt_val;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_LIST_LIMIT;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk. Starts on the reset registers, then narrows the list so
    // both passes, removal, replay and the clamped limits are all reached.
    script = '{
      // reset registers, no previous vertex, lift without vertex, plain miss
      known_row(20'h00000, 1'b1, 1'b0, DELEGATED),
      known_row(20'hFFFFF, 1'b1, 1'b1, DELEGATED),
      known_row(20'hFFFFF, 1'b0, 1'b0, DELEGATED),
      write_row(CFG_LIST_LIMIT, 21'd2),
      known_row(20'hFFFFF, 1'b0, 1'b1, DELEGATED),
      // second append fills the list: head comes out in pass two
      known_row(20'h00000, 1'b0, 1'b1, '{vertex: 20'hFFFFF, delegate: 1'b0, focus: 1'b1}),
      report_row(20'h12345, 1'b0, 1'b1),    // reported vertex differs from the entry
      report_row(20'h00000, 1'b0, 1'b0),
      report_row(20'h00000, 1'b1, 1'b0),    // no previous vertex: back to the head
      report_row(20'hFFFFF, 1'b0, 1'b0),
      report_row(20'h00000, 1'b0, 1'b0),    // credit runs out, tail entry removed
      report_row(20'hFFFFF, 1'b0, 1'b0),
      report_row(20'hFFFFF, 1'b0, 1'b0),    // list empties, pass-one report replayed
      write_row(CFG_VERTEX_COUNT, 21'd1),
      report_row(20'h00005, 1'b0, 1'b0),    // attempt count ends pass one
      report_row(20'h00000, 1'b0, 1'b0),
      report_row(20'h00000, 1'b0, 1'b0),
      report_row(20'h00006, 1'b0, 1'b0),    // empty list at the switch
      write_row(CFG_LIST_LIMIT, 21'd0),     // clamped up to one
      write_row(CFG_VERTEX_COUNT, 21'h1FFFFF),
      known_row(20'hABCDE, 1'b0, 1'b1, '{vertex: 20'hABCDE, delegate: 1'b0, focus: 1'b1}),
      report_row(20'hABCDE, 1'b0, 1'b1),
      report_row(20'hABCDE, 1'b0, 1'b0),
      report_row(20'hABCDE, 1'b0, 1'b0),
      report_row(20'hABCDE, 1'b0, 1'b0),    // replay re-appends and re-enters pass two
      write_row(CFG_LIST_LIMIT, 21'd2047),  // clamped down to the list depth
      write_row(CFG_VERTEX_COUNT, 21'h100000),
      report_row(20'h00000, 1'b1, 1'b0)
    };
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (i == 0 || script[i-1].kind != ROW_WRITE) settle();
        write_register(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer_report(script[i].vertex, script[i].none, script[i].lifted,
                     script[i].typed, script[i].want);
      end
    end

    // Random phases, each on fresh registers. Most reports are well formed:
    // in pass two they name the vertex just handed out; a few are noise.
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES / 2) begin
        // Single-entry credit run. Drain the list on a limit that cannot
        // trap the replay, then cycle one entry with lifts only.
        settle();
        write_register(CFG_LIST_LIMIT, 21'd1024);
        write_register(CFG_VERTEX_COUNT, 21'h1FFFFF);
        idle_pct = 33;
        while (in_pass_two) offer_report(handed_vertex, 1'b0, 1'b0, 1'b0, '0);
        settle();
        write_register(CFG_LIST_LIMIT, 21'd1);
        while (!in_pass_two) offer_report(VBITS'($urandom), 1'b0, fl_len == 0, 1'b0, '0);
        repeat (SOAK_LIFTS) offer_report(handed_vertex, 1'b0, 1'b1, 1'b0, '0);
        // a run of misses halves the credit to zero and empties the list
        repeat (8) offer_report(handed_vertex, 1'b0, 1'b0, 1'b0, '0);
      end

      case ($urandom_range(9))
        0:       lim_val = 21'd0;
        1:       lim_val = 21'd2047;
        2:       lim_val = 21'd1024;
        3:       lim_val = 21'd1;
        4:       lim_val = CFG_DATA_W'($urandom_range(2047));
        default: lim_val = CFG_DATA_W'($urandom_range(12, 1));
      endcase
      case ($urandom_range(9))
        0:       cnt_val = 21'd0;
        1:       cnt_val = 21'h1FFFFF;
        2:       cnt_val = 21'h100000;
        3:       cnt_val = CFG_DATA_W'($urandom);
        default: cnt_val = CFG_DATA_W'($urandom_range(40, 1));
      endcase
      settle();
      write_register(CFG_LIST_LIMIT, lim_val);
      write_register(CFG_VERTEX_COUNT, cnt_val);
      idle_pct = (phase == 2) ? 0 : 33;   // one long stretch with no idling
      lift_pct = $urandom_range(75, 30);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        // hold the sender off until the block has caught up
        if ((phase == 1 && k == PHASE_ITEMS / 2) || $urandom_range(199) == 0) settle();
        if (in_pass_two) begin
          none   = ($urandom_range(99) < 4);
          lifted = ($urandom_range(99) < lift_pct);
          v      = ($urandom_range(99) < 90) ? handed_vertex : VBITS'($urandom);
        end else begin
          none   = ($urandom_range(99) < 5);
          lifted = ($urandom_range(99) < 50);
          v      = VBITS'($urandom);
        end
        offer_report(v, none, lifted, 1'b0, '0);
      end
    end

    settle();
    repeat (50) @(posedge clk);   // catch any stray result
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* focus_list_vertex_scheduler_top.f */
hw/rtl/fvs_pkg.sv
hw/rtl/fvs_list_mem.sv
hw/rtl/fvs_ctrl.sv
hw/rtl/focus_list_vertex_scheduler_top.sv
tb/tb_focus_list_vertex_scheduler_top.sv
